### src/rbs_pkg.sv
// shared constants, types and register codes for the ray/box slab test
// no dependencies; compiled before every other file of the block
package rbs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int NUM_W     = COORD_W + FRAC_BITS;
    localparam int QUO_W     = COORD_W - 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_LAT   = DIV_STEPS + 3;
    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] p;
        logic [QUO_W-1:0]   low;
        logic [QUO_W-1:0]   q;
        logic               ovf;
        logic               neg;
    } div_stage_t;

    typedef struct packed {
        logic            vld;
        logic [AXES-1:0] pmiss;
    } side_t;

endpackage

### src/rbs_ifs.sv
// valid/ready channel interfaces for box beats and result beats
// depends on rbs_pkg
interface rbs_box_if;
    import rbs_pkg::*;

    logic   valid;
    logic   ready;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface rbs_result_if;
    import rbs_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic [QUO_W-1:0] entry_distance;

    modport source (
        output valid, hit, entry_distance,
        input  ready
    );
    modport sink (
        input  valid, hit, entry_distance,
        output ready
    );
endinterface

### src/rbs_divider.sv
// pipelined slab distance: ((corner - origin) << FRAC_BITS) / dir, saturated
// one restoring quotient bit per stage; depends on rbs_pkg
module rbs_divider (
    input  logic                         clk,
    input  logic                         adv,
    input  rbs_pkg::coord_t              corner,
    input  rbs_pkg::coord_t              origin,
    input  logic [rbs_pkg::COORD_W-1:0]  dir_mag,
    input  logic                         dir_neg,
    output rbs_pkg::coord_t              quot
);
    import rbs_pkg::*;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic [DIFF_W-1:0]        diff_abs;
    logic [NUM_W-1:0]         num;
    logic [COORD_W-1:0]       num_top;
    div_stage_t               st_reg  [DIV_STEPS+1];
    div_stage_t               st_next [DIV_STEPS+1];
    coord_t                   quot_reg;
    coord_t                   quot_next;

    function automatic div_stage_t div_step(div_stage_t s, logic [COORD_W-1:0] d);
        logic [COORD_W:0] trial;
        div_stage_t       r;
        r     = s;
        trial = {s.p, s.low[QUO_W-1]};
        r.low = {s.low[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            r.p = COORD_W'(trial - {1'b0, d});
            r.q = {s.q[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.p = trial[COORD_W-1:0];
            r.q = {s.q[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    assign diff_next = {corner[COORD_W-1], corner} - {origin[COORD_W-1], origin};

    // magnitude scaled; quotient fits 31 bits unless top part reaches divisor
    assign diff_abs = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign num      = {diff_abs[COORD_W-1:0], {FRAC_BITS{1'b0}}};
    assign num_top  = COORD_W'(num[NUM_W-1:QUO_W]);

    assign st_next[0] = '{
        p:   num_top,
        low: num[QUO_W-1:0],
        q:   '0,
        ovf: (num_top >= dir_mag),
        neg: diff_reg[DIFF_W-1] ^ dir_neg
    };

    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++)
        begin : g_step
            assign st_next[j+1] = div_step(st_reg[j], dir_mag);
        end
    endgenerate

    always_comb
    begin
        if (st_reg[DIV_STEPS].ovf)
            quot_next = st_reg[DIV_STEPS].neg ? T_MIN : T_MAX;
        else if (st_reg[DIV_STEPS].neg)
            quot_next = -coord_t'({1'b0, st_reg[DIV_STEPS].q});
        else
            quot_next = coord_t'({1'b0, st_reg[DIV_STEPS].q});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= diff_next;
            for (int i = 0; i <= DIV_STEPS; i++)
                st_reg[i] <= st_next[i];
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

### src/rbs_interval.sv
// orders slab distances per axis, narrows the interval and forms the result
// three register stages, the last being the output register; depends on rbs_pkg
module rbs_interval (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  rbs_pkg::side_t             side,
    input  rbs_pkg::coord_t            t0 [rbs_pkg::AXES],
    input  rbs_pkg::coord_t            t1 [rbs_pkg::AXES],
    input  logic [rbs_pkg::AXES-1:0]   dir_zero,
    output logic                       out_valid,
    output logic                       hit,
    output logic [rbs_pkg::QUO_W-1:0]  entry
);
    import rbs_pkg::*;

    coord_t           lo_reg [AXES];
    coord_t           hi_reg [AXES];
    coord_t           lo_next [AXES];
    coord_t           hi_next [AXES];
    logic             vld1_reg;
    logic             miss1_reg;
    coord_t           tmin_reg;
    coord_t           tmax_reg;
    coord_t           tmin_next;
    coord_t           tmax_next;
    logic             vld2_reg;
    logic             miss2_reg;
    logic             vld3_reg;
    logic             hit_reg;
    logic             hit_next;
    logic [QUO_W-1:0] entry_reg;
    logic [QUO_W-1:0] entry_next;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (t0[a] > t1[a])
            begin
                lo_next[a] = t1[a];
                hi_next[a] = t0[a];
            end
            else
            begin
                lo_next[a] = t0[a];
                hi_next[a] = t1[a];
            end
        end
    end

    // parallel axes do not narrow
    always_comb
    begin
        tmin_next = '0;
        tmax_next = T_MAX;
        for (int a = 0; a < AXES; a++)
        begin
            if (!dir_zero[a])
            begin
                if (lo_reg[a] > tmin_next)
                    tmin_next = lo_reg[a];
                if (hi_reg[a] < tmax_next)
                    tmax_next = hi_reg[a];
            end
        end
    end

    assign hit_next   = !miss2_reg && (tmin_reg <= tmax_reg);
    assign entry_next = hit_next ? tmin_reg[QUO_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= side.vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            miss1_reg <= |side.pmiss;
            tmin_reg  <= tmin_next;
            tmax_reg  <= tmax_next;
            miss2_reg <= miss1_reg;
            hit_reg   <= hit_next;
            entry_reg <= entry_next;
        end
    end

    assign out_valid = vld3_reg;
    assign hit       = hit_reg;
    assign entry     = entry_reg;

endmodule

### src/ray_box_slab_test.sv
// ray against axis-aligned box slab test, one box beat in, one result beat out
// path from box beat to result beat: the per-corner dividers (one quotient bit
// per stage), then ordering, narrowing and the output register
// throughput one box per cycle; the whole pipeline holds while a result waits
// reset clears the valid bits and the origin/direction registers to zero
module ray_box_slab_test (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbs_pkg::COORD_W-1:0]    cfg_data,
    rbs_box_if.sink                        box,
    rbs_result_if.source                   result
);
    import rbs_pkg::*;

    coord_t             origin_reg  [AXES];
    logic [COORD_W-1:0] dir_mag_reg [AXES];
    logic [AXES-1:0]    dir_neg_reg;
    logic [AXES-1:0]    dir_zero_reg;
    logic [COORD_W-1:0] cfg_mag;

    coord_t             lo [AXES];
    coord_t             hi [AXES];
    coord_t             t0 [AXES];
    coord_t             t1 [AXES];
    logic [AXES-1:0]    pmiss;
    side_t              side_reg [DIV_LAT];
    side_t              side_next;
    logic               adv;
    logic               out_valid;

    assign cfg_mag = cfg_data[COORD_W-1] ? COORD_W'(-cfg_data) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                origin_reg[a]  <= '0;
                dir_mag_reg[a] <= '0;
            end
            dir_neg_reg  <= '0;
            dir_zero_reg <= '1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                REG_DIR_X:
                begin
                    dir_mag_reg[0]  <= cfg_mag;
                    dir_neg_reg[0]  <= cfg_data[COORD_W-1];
                    dir_zero_reg[0] <= (cfg_data == '0);
                end
                REG_DIR_Y:
                begin
                    dir_mag_reg[1]  <= cfg_mag;
                    dir_neg_reg[1]  <= cfg_data[COORD_W-1];
                    dir_zero_reg[1] <= (cfg_data == '0);
                end
                REG_DIR_Z:
                begin
                    dir_mag_reg[2]  <= cfg_mag;
                    dir_neg_reg[2]  <= cfg_data[COORD_W-1];
                    dir_zero_reg[2] <= (cfg_data == '0);
                end
                default: ;
            endcase
        end
    end

    assign lo[0] = box.box_min_x;
    assign lo[1] = box.box_min_y;
    assign lo[2] = box.box_min_z;
    assign hi[0] = box.box_max_x;
    assign hi[1] = box.box_max_y;
    assign hi[2] = box.box_max_z;

    // parallel axis misses when the origin is outside the slab
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
            pmiss[a] = dir_zero_reg[a] && ((origin_reg[a] < lo[a]) || (origin_reg[a] > hi[a]));
    end

    assign adv       = !out_valid || result.ready;
    assign box.ready = adv;

    assign side_next = '{vld: box.valid, pmiss: pmiss};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                side_reg[i] <= '0;
        end
        else if (adv)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    genvar a;
    generate
        for (a = 0; a < AXES; a++)
        begin : g_axis
            rbs_divider u_div_lo (
                .clk     (clk),
                .adv     (adv),
                .corner  (lo[a]),
                .origin  (origin_reg[a]),
                .dir_mag (dir_mag_reg[a]),
                .dir_neg (dir_neg_reg[a]),
                .quot    (t0[a])
            );

            rbs_divider u_div_hi (
                .clk     (clk),
                .adv     (adv),
                .corner  (hi[a]),
                .origin  (origin_reg[a]),
                .dir_mag (dir_mag_reg[a]),
                .dir_neg (dir_neg_reg[a]),
                .quot    (t1[a])
            );
        end
    endgenerate

    rbs_interval u_interval (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .side      (side_reg[DIV_LAT-1]),
        .t0        (t0),
        .t1        (t1),
        .dir_zero  (dir_zero_reg),
        .out_valid (out_valid),
        .hit       (result.hit),
        .entry     (result.entry_distance)
    );

    assign result.valid = out_valid;

endmodule

### tb/sv/ray_box_slab_check.sv
// result checker for the ray/box slab test: follows register writes, predicts every box beat
// and compares each result beat in order; depends on rbs_pkg and the channel interfaces
module ray_box_slab_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbs_pkg::COORD_W-1:0]   cfg_data,
    rbs_box_if                            box,
    rbs_result_if                         result,
    output int                            fail_count,
    output int                            pending
);
    import rbs_pkg::*;

    typedef struct {
        logic             hit;
        logic [QUO_W-1:0] entry;
    } slab_result_t;

    coord_t       ray_org [AXES];
    coord_t       ray_dir [AXES];
    coord_t       lo_v [AXES];
    coord_t       hi_v [AXES];
    slab_result_t expected_q [$];
    slab_result_t exp_r;
    int           beat_count;

    task automatic report_mismatch(string what, longint got_v, longint exp_v);
        $display("result beat %0d: %s got %0d expected %0d", beat_count, what, got_v, exp_v);
        fail_count++;
    endtask

    function automatic longint slab_time(longint corner, longint org, longint dir);
        longint num;
        longint q;
        num = (corner - org) * (longint'(1) <<< FRAC_BITS);
        q = num / dir;
        if (q > longint'(T_MAX))
            q = longint'(T_MAX);
        if (q < longint'(T_MIN))
            q = longint'(T_MIN);
        return q;
    endfunction

    function automatic slab_result_t predict_box(input coord_t lo [AXES], input coord_t hi [AXES]);
        slab_result_t r;
        longint       t_near;
        longint       t_far;
        longint       t0;
        longint       t1;
        longint       s;
        logic         hit_f;
        t_near = 0;
        t_far  = longint'(T_MAX);
        hit_f  = 1'b1;
        for (int a = 0; a < AXES && hit_f; a++)
        begin
            if (ray_dir[a] == 0)
            begin
                // parallel axis: origin must sit inside the slab
                if (ray_org[a] < lo[a] || ray_org[a] > hi[a])
                    hit_f = 1'b0;
            end
            else
            begin
                t0 = slab_time(lo[a], ray_org[a], ray_dir[a]);
                t1 = slab_time(hi[a], ray_org[a], ray_dir[a]);
                if (t0 > t1)
                begin
                    s  = t0;
                    t0 = t1;
                    t1 = s;
                end
                if (t0 > t_near)
                    t_near = t0;
                if (t1 < t_far)
                    t_far = t1;
                if (t_near > t_far)
                    hit_f = 1'b0;
            end
        end
        r.hit   = hit_f;
        r.entry = hit_f ? t_near[QUO_W-1:0] : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                ray_org[a] = '0;
                ray_dir[a] = '0;
            end
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
            beat_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ORIGIN_X: ray_org[0] = cfg_data;
                    REG_ORIGIN_Y: ray_org[1] = cfg_data;
                    REG_ORIGIN_Z: ray_org[2] = cfg_data;
                    REG_DIR_X:    ray_dir[0] = cfg_data;
                    REG_DIR_Y:    ray_dir[1] = cfg_data;
                    REG_DIR_Z:    ray_dir[2] = cfg_data;
                    default: ;
                endcase
            end
            if (box.valid && box.ready)
            begin
                lo_v[0] = box.box_min_x;
                lo_v[1] = box.box_min_y;
                lo_v[2] = box.box_min_z;
                hi_v[0] = box.box_max_x;
                hi_v[1] = box.box_max_y;
                hi_v[2] = box.box_max_z;
                expected_q = {expected_q, predict_box(lo_v, hi_v)};
            end
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("beat with nothing expected, hit",
                                    longint'(result.hit), longint'(0));
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.hit !== exp_r.hit)
                        report_mismatch("hit", longint'(result.hit), longint'(exp_r.hit));
                    if (result.entry_distance !== exp_r.entry)
                        report_mismatch("entry_distance", longint'(result.entry_distance),
                                        longint'(exp_r.entry));
                end
                beat_count++;
            end
            pending = expected_q.size();
        end
    end

endmodule

### tb/sv/ray_box_slab_test_tb.sv
// top of the ray/box slab test bench: clock, reset, ray register phases, box stimulus
// with bursty sending and result stalls; depends on rbs_pkg, the interfaces and the checker
module ray_box_slab_test_tb;
    import rbs_pkg::*;

    localparam coord_t ONE = coord_t'(1 <<< FRAC_BITS);

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    int                   fails;
    int                   pending;

    rbs_box_if    box ();
    rbs_result_if result ();

    coord_t ray_o [AXES];
    coord_t ray_d [AXES];
    int     burst_left;
    int     stall_mode;
    int     stall_left;
    int     cyc;

    always #6 clk = ~clk;

    ray_box_slab_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box       (box),
        .result    (result)
    );

    ray_box_slab_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .box        (box),
        .result     (result),
        .fail_count (fails),
        .pending    (pending)
    );

    // receiver stall pattern in one of four modes, picked at random anew when its run count expires
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        cyc++;
        case (stall_mode)
            0: result.ready = 1'b1;
            1: result.ready = $urandom_range(0, 1);
            2: result.ready = ($urandom_range(0, 7) == 0);
            default: result.ready = (cyc % 5 != 4) && (cyc % 7 != 0);
        endcase
    end

    function automatic coord_t clamp_coord(longint v);
        if (v > longint'(T_MAX))
            return T_MAX;
        if (v < longint'(T_MIN))
            return T_MIN;
        return coord_t'(v);
    endfunction

    function automatic coord_t small_coord();
        return coord_t'(int'($urandom_range(0, 32 << FRAC_BITS)) - (16 << FRAC_BITS));
    endfunction

    function automatic coord_t edge_coord();
        case ($urandom_range(0, 5))
            0: return T_MIN;
            1: return T_MAX;
            2: return '0;
            3: return '1;
            4: return coord_t'(1);
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic coord_t pick_origin();
        case ($urandom_range(0, 7))
            6: return coord_t'($urandom());
            7: return edge_coord();
            default: return small_coord();
        endcase
    endfunction

    function automatic coord_t pick_dir();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom_range(0, 1) ? coord_t'(1) : coord_t'(-1);
            2: return $urandom_range(0, 1) ? T_MIN : T_MAX;
            3: return coord_t'($urandom());
            default: return coord_t'(int'($urandom_range(0, 4 << FRAC_BITS)) - (2 << FRAC_BITS));
        endcase
    endfunction

    task automatic send_box(coord_t mnx, coord_t mny, coord_t mnz,
                            coord_t mxx, coord_t mxy, coord_t mxz);
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                box.valid = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        box.box_min_x = mnx;
        box.box_min_y = mny;
        box.box_min_z = mnz;
        box.box_max_x = mxx;
        box.box_max_y = mxy;
        box.box_max_z = mxz;
        box.valid     = 1'b1;
        do
            @(posedge clk);
        while (!box.ready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic write_reg(cfg_reg_t idx, coord_t val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
    endtask

    task automatic set_ray(coord_t ox, coord_t oy, coord_t oz,
                           coord_t dx, coord_t dy, coord_t dz);
        box.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        cfg_wr_en = 1'b0;
        ray_o[0] = ox;
        ray_o[1] = oy;
        ray_o[2] = oz;
        ray_d[0] = dx;
        ray_d[1] = dy;
        ray_d[2] = dz;
    endtask

    task automatic send_random_box();
        coord_t lo [AXES];
        coord_t hi [AXES];
        coord_t s;
        longint t;
        longint c;
        longint h;
        int     kind;
        kind = $urandom_range(0, 9);
        t = longint'($urandom_range(0, 16 << FRAC_BITS));
        for (int a = 0; a < AXES; a++)
        begin
            case (kind)
                0, 1, 2, 3, 4:
                begin
                    // box placed around a point on the ray
                    c = longint'(ray_o[a]) + ((longint'(ray_d[a]) * t) >>> FRAC_BITS);
                    h = longint'($urandom_range(0, 4 << FRAC_BITS));
                    lo[a] = clamp_coord(c - h);
                    hi[a] = clamp_coord(c + h + longint'($urandom_range(0, 255)));
                end
                5, 6, 7:
                begin
                    lo[a] = small_coord();
                    hi[a] = small_coord();
                    if ((lo[a] > hi[a]) != (kind == 7))
                    begin
                        s     = lo[a];
                        lo[a] = hi[a];
                        hi[a] = s;
                    end
                end
                8:
                begin
                    lo[a] = coord_t'($urandom());
                    hi[a] = coord_t'($urandom());
                end
                default:
                begin
                    lo[a] = edge_coord();
                    hi[a] = edge_coord();
                end
            endcase
        end
        send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        box.valid     = 1'b0;
        box.box_min_x = '0;
        box.box_min_y = '0;
        box.box_min_z = '0;
        box.box_max_x = '0;
        box.box_max_y = '0;
        box.box_max_z = '0;
        result.ready  = 1'b0;
        burst_left    = 0;
        stall_mode    = 0;
        stall_left    = 0;
        cyc           = 0;
        for (int a = 0; a < AXES; a++)
        begin
            ray_o[a] = '0;
            ray_d[a] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset ray: all axes parallel
        send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_box(ONE, -ONE, -ONE, 2 * ONE, ONE, ONE);

        set_ray('0, '0, '0, ONE, ONE, ONE);
        send_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE);
        send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_box(-3 * ONE, -3 * ONE, -3 * ONE, -2 * ONE, -2 * ONE, -2 * ONE);
        send_box(2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE);
        send_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX);
        send_box('0, '0, '0, '0, '0, '0);
        send_box(T_MAX - ONE, T_MAX - ONE, T_MAX - ONE, T_MAX, T_MAX, T_MAX);
        send_box(ONE, 3 * ONE, ONE, 2 * ONE, 4 * ONE, 2 * ONE);

        set_ray(ONE, '0, '0, '0, ONE, -ONE);
        send_box('0, -4 * ONE, -3 * ONE, 2 * ONE, 4 * ONE, -ONE);
        send_box(2 * ONE, -4 * ONE, -3 * ONE, 3 * ONE, 4 * ONE, -ONE);
        send_box(ONE, -4 * ONE, -3 * ONE, 2 * ONE, 4 * ONE, -ONE);
        send_box('0, -4 * ONE, -3 * ONE, ONE, 4 * ONE, -ONE);
        send_box(2 * ONE, -4 * ONE, -3 * ONE, '0, 4 * ONE, -ONE);

        set_ray(T_MIN, T_MAX, '0, coord_t'(1), coord_t'(-1), T_MIN);
        send_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX);
        send_box('0, '0, '0, '0, '0, '0);
        send_box(T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN);

        set_ray(T_MAX, T_MIN, T_MAX, T_MAX, T_MAX, coord_t'(1));
        send_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX);
        send_box('1, '1, '1, '0, '0, '0);

        for (int p = 0; p < 10; p++)
        begin
            set_ray(pick_origin(), pick_origin(), pick_origin(),
                    pick_dir(), pick_dir(), pick_dir());
            repeat (125) send_random_box();
        end

        box.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DIV_LAT + 12) @(negedge clk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
src/rbs_pkg.sv
src/rbs_ifs.sv
src/rbs_divider.sv
src/rbs_interval.sv
src/ray_box_slab_test.sv
tb/sv/ray_box_slab_check.sv
tb/sv/ray_box_slab_test_tb.sv
